// File: rtl/core/vbc_pkg.sv
// ----------------------------------------------------------------------------
// vbc_pkg
// Shared widths, codes and types of the verdict batch coalescer.
// ----------------------------------------------------------------------------
package vbc_pkg;

  // Field widths
  localparam int NOW_W      = 48;
  localparam int TIMEOUT_W  = 48;
  localparam int ID_W       = 32;
  localparam int CNT_W      = 16;
  localparam int VERD_W     = 3;
  localparam int MASK_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  // Default wrap width of the elapsed-time arithmetic
  localparam int TIME_BITS_DEF = 48;

  // Result queue geometry
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  // Verdict codes
  localparam logic [VERD_W-1:0] NO_MATCH_CODE   = 3'd6;
  localparam logic [VERD_W-1:0] NO_VERDICT_MARK = 3'd5;

  // Count saturation
  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  // Register reset values
  localparam logic [CNT_W-1:0]     LIMIT_RST   = 16'd1;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 48'hFFFF_FFFF_FFFF;
  localparam logic [VERD_W-1:0]    DEF_VERD_RST = 3'd1;

  // Chain codes
  localparam logic CHAIN_IN  = 1'b0;
  localparam logic CHAIN_OUT = 1'b1;

  // Request kinds
  localparam logic MODE_PACKET = 1'b0;
  localparam logic MODE_POLL   = 1'b1;

  // Poll mask bits
  localparam int POLL_BIT_IN  = 0;
  localparam int POLL_BIT_OUT = 1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BATCH_LIMIT     = 2'd0,
    REG_BATCH_TIMEOUT   = 2'd1,
    REG_DEF_VERDICT_IN  = 2'd2,
    REG_DEF_VERDICT_OUT = 2'd3
  } cfg_reg_t;

  // One batch release
  typedef struct packed {
    logic              chain;
    logic [ID_W-1:0]   pkt_id;
    logic [VERD_W-1:0] verdict;
    logic [CNT_W-1:0]  count;
    logic              last;
  } flush_t;

endpackage

// File: rtl/core/verdict_batch_coalescer_top.sv
// ----------------------------------------------------------------------------
// verdict_batch_coalescer_top
// A request is captured in the input register, and its releases are written
// to the result queue, which offers them on the result port.
// Throughput: one request per cycle while the queue has room; the releases of
// a request leave through the single result port one at a time, and the
// 4-entry result queue pauses the input register when it holds more than two.
// Reset (rst_n low, synchronous): registers to defaults, batches emptied,
// queue and input register cleared.
// ----------------------------------------------------------------------------
module verdict_batch_coalescer_top #(
  parameter int TIME_BITS = vbc_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [vbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vbc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_mode,
  input  logic                           in_chain,
  input  logic [vbc_pkg::MASK_W-1:0]     in_poll_mask,
  input  logic                           in_force_req,
  input  logic [vbc_pkg::ID_W-1:0]       in_pkt_id,
  input  logic [vbc_pkg::VERD_W-1:0]     in_rule_verdict,
  input  logic                           in_is_tcp,
  input  logic                           in_tcp_syn,
  input  logic                           in_tcp_psh,
  input  logic [vbc_pkg::NOW_W-1:0]      in_now_us,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_flush_chain,
  output logic [vbc_pkg::ID_W-1:0]       out_flush_pkt_id,
  output logic [vbc_pkg::VERD_W-1:0]     out_flush_verdict,
  output logic [vbc_pkg::CNT_W-1:0]      out_flush_count,
  output logic                           out_last_flag
);
  import vbc_pkg::*;

  localparam int CMP_W = (TIME_BITS > TIMEOUT_W) ? TIME_BITS : TIMEOUT_W;

  // Configuration registers
  logic [CNT_W-1:0]     limit_r;
  logic [TIMEOUT_W-1:0] timeout_r;
  logic [VERD_W-1:0]    def_in_r;
  logic [VERD_W-1:0]    def_out_r;

  // Per-chain batch state
  logic [CNT_W-1:0]     pend_r   [2];
  logic [CNT_W-1:0]     pend_nxt [2];
  logic [ID_W-1:0]      id_r     [2];
  logic [ID_W-1:0]      id_nxt   [2];
  logic [VERD_W-1:0]    verd_r   [2];
  logic [VERD_W-1:0]    verd_nxt [2];
  logic [TIME_BITS-1:0] old_r    [2];
  logic [TIME_BITS-1:0] old_nxt  [2];

  // Input register
  logic                 s_vld_r;
  logic                 s_mode_r;
  logic                 s_chain_r;
  logic [MASK_W-1:0]    s_mask_r;
  logic                 s_force_r;
  logic [ID_W-1:0]      s_id_r;
  logic [VERD_W-1:0]    s_rv_r;
  logic                 s_tcp_r;
  logic                 s_syn_r;
  logic                 s_psh_r;
  logic [NOW_W-1:0]     s_now_r;

  // Result queue
  flush_t               res_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wptr_r;
  logic [RES_PTR_W-1:0] rptr_r;
  logic [RES_CNT_W-1:0] cnt_r;
  logic [RES_PTR_W-1:0] wptr_p1;

  // Single-pass logic
  logic                 proc;
  logic                 pop;
  logic [TIME_BITS-1:0] now_t;
  logic                 tmo_hit [2];
  logic                 c;
  logic [VERD_W-1:0]    v;
  logic [CNT_W-1:0]     pc;
  logic [CNT_W-1:0]     pc_mid;
  logic [CNT_W-1:0]     pc2;
  logic                 f1;
  logic                 f2;
  logic                 hit2;
  logic                 fo;
  logic                 fi;
  logic                 a_v;
  logic                 b_v;
  flush_t               a_d;
  flush_t               b_d;
  flush_t               wr0;
  logic [1:0]           wr_n;

  // Hold the input register while the queue lacks room for two results
  assign proc     = s_vld_r && (cnt_r <= RES_CNT_W'(RES_DEPTH - 2));
  assign in_stall = s_vld_r && !proc;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;

  assign out_flush_chain   = res_q[rptr_r].chain;
  assign out_flush_pkt_id  = res_q[rptr_r].pkt_id;
  assign out_flush_verdict = res_q[rptr_r].verdict;
  assign out_flush_count   = res_q[rptr_r].count;
  assign out_last_flag     = res_q[rptr_r].last;

  assign now_t   = TIME_BITS'(s_now_r);
  assign wptr_p1 = wptr_r + 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= LIMIT_RST;
      timeout_r <= TIMEOUT_RST;
      def_in_r  <= DEF_VERD_RST;
      def_out_r <= DEF_VERD_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BATCH_LIMIT:     limit_r   <= cfg_wdata[CNT_W-1:0];
        REG_BATCH_TIMEOUT:   timeout_r <= cfg_wdata[TIMEOUT_W-1:0];
        REG_DEF_VERDICT_IN:  def_in_r  <= cfg_wdata[VERD_W-1:0];
        REG_DEF_VERDICT_OUT: def_out_r <= cfg_wdata[VERD_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture a request into the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s_mode_r  <= in_mode;
      s_chain_r <= in_chain;
      s_mask_r  <= in_poll_mask;
      s_force_r <= in_force_req;
      s_id_r    <= in_pkt_id;
      s_rv_r    <= in_rule_verdict;
      s_tcp_r   <= in_is_tcp;
      s_syn_r   <= in_tcp_syn;
      s_psh_r   <= in_tcp_psh;
      s_now_r   <= in_now_us;
    end
  end

  // Compare each chain's batch age with the timeout
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      tmo_hit[i] = (CMP_W'(TIME_BITS'(now_t - old_r[i])) >= CMP_W'(timeout_r));
    end
  end

  // Resolve the request, pick releases and update batch state
  always_comb begin
    pend_nxt = pend_r;
    id_nxt   = id_r;
    verd_nxt = verd_r;
    old_nxt  = old_r;

    // packet path
    c      = s_chain_r;
    v      = (s_rv_r >= NO_MATCH_CODE) ? ((c == CHAIN_OUT) ? def_out_r : def_in_r) : s_rv_r;
    pc     = pend_r[c];
    f1     = (v != verd_r[c]) && (pc != '0);
    pc_mid = f1 ? '0 : pc;
    pc2    = (pc_mid != CNT_MAX) ? pc_mid + 1'b1 : CNT_MAX;
    // a fresh batch has zero age
    hit2   = (pc_mid == '0) ? (timeout_r == '0) : tmo_hit[c];
    f2     = (s_tcp_r && (s_syn_r || s_psh_r)) || (pc2 >= limit_r) || hit2;

    // poll path: output chain first, then input chain
    fo = s_mask_r[POLL_BIT_OUT] && (pend_r[CHAIN_OUT] != '0) &&
         (s_force_r || (pend_r[CHAIN_OUT] >= limit_r) || tmo_hit[CHAIN_OUT]);
    fi = s_mask_r[POLL_BIT_IN] && (pend_r[CHAIN_IN] != '0) &&
         (s_force_r || (pend_r[CHAIN_IN] >= limit_r) || tmo_hit[CHAIN_IN]);

    a_v = 1'b0;
    b_v = 1'b0;
    a_d = '0;
    b_d = '0;

    if (proc) begin
      if (s_mode_r == MODE_PACKET) begin
        // flush on verdict change, then add the packet
        a_v = f1;
        a_d = {c, id_r[c], verd_r[c], pc, 1'b0};
        b_v = f2;
        b_d = {c, s_id_r, v, pc2, 1'b0};
        verd_nxt[c] = v;
        id_nxt[c]   = s_id_r;
        if (pc_mid == '0) begin
          old_nxt[c] = now_t;
        end
        pend_nxt[c] = f2 ? '0 : pc2;
      end else begin
        a_v = fo;
        a_d = {CHAIN_OUT, id_r[CHAIN_OUT], verd_r[CHAIN_OUT], pend_r[CHAIN_OUT], 1'b0};
        b_v = fi;
        b_d = {CHAIN_IN, id_r[CHAIN_IN], verd_r[CHAIN_IN], pend_r[CHAIN_IN], 1'b0};
        if (fo) begin
          pend_nxt[CHAIN_OUT] = '0;
        end
        if (fi) begin
          pend_nxt[CHAIN_IN] = '0;
        end
      end
    end

    // mark the last release of this request
    if (b_v) begin
      b_d.last = 1'b1;
    end else begin
      a_d.last = 1'b1;
    end

    wr0  = a_v ? a_d : b_d;
    wr_n = {1'b0, a_v} + {1'b0, b_v};
  end

  // Hold batch state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        pend_r[i] <= '0;
        id_r[i]   <= '0;
        verd_r[i] <= NO_VERDICT_MARK;
        old_r[i]  <= '0;
      end
    end else begin
      pend_r <= pend_nxt;
      id_r   <= id_nxt;
      verd_r <= verd_nxt;
      old_r  <= old_nxt;
    end
  end

  // Advance result queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_r + RES_PTR_W'(wr_n);
      rptr_r <= rptr_r + RES_PTR_W'(pop);
      cnt_r  <= cnt_r + RES_CNT_W'(wr_n) - RES_CNT_W'(pop);
    end
  end

  // Store releases
  always_ff @(posedge clk) begin
    if (wr_n != 2'd0) begin
      res_q[wptr_r] <= wr0;
    end
    if (wr_n == 2'd2) begin
      res_q[wptr_p1] <= b_d;
    end
  end

endmodule

// File: rtl/core/vbc_checker.sv
// ----------------------------------------------------------------------------
// vbc_checker
// Port-level checks of the verdict batch coalescer, bound to the top level.
// ----------------------------------------------------------------------------
module vbc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_flush_chain,
  input logic [vbc_pkg::ID_W-1:0]   out_flush_pkt_id,
  input logic [vbc_pkg::VERD_W-1:0] out_flush_verdict,
  input logic [vbc_pkg::CNT_W-1:0]  out_flush_count,
  input logic                       out_last_flag
);

  // Reset empties the result queue
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A released batch is never empty
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_flush_count != '0))
    else $error("empty batch released");

  // Both releases of one request are queued together
  a_second_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_flag) |=> out_valid)
    else $error("second release of a request missing");

  // A stalled release holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_flush_pkt_id) && $stable(out_flush_count) &&
       $stable(out_flush_chain) && $stable(out_flush_verdict) &&
       $stable(out_last_flag)))
    else $error("stalled release changed");

endmodule

bind verdict_batch_coalescer_top vbc_checker u_vbc_checker (.*);

// File: verif/verdict_batch_coalescer_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// verdict_batch_coalescer_top_test
// Drives packet and poll requests into the coalescer under random idling on
// both channels, predicts every batch release in step with each accepted
// request and compares the released batches field by field, in order.
// ----------------------------------------------------------------------------
module verdict_batch_coalescer_top_test;
  import vbc_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 6;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_REQS   = 240;
  localparam int FULL_BATCH   = 24;
  localparam logic [NOW_W-1:0] NOW_MAX = '1;

  typedef struct packed {
    logic              mode;
    logic              chain;
    logic [MASK_W-1:0] poll_mask;
    logic              force_req;
    logic [ID_W-1:0]   pkt_id;
    logic [VERD_W-1:0] rule_verdict;
    logic              is_tcp;
    logic              tcp_syn;
    logic              tcp_psh;
    logic [NOW_W-1:0]  now_us;
  } coal_req_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_mode = 1'b0;
  logic                  in_chain = 1'b0;
  logic [MASK_W-1:0]     in_poll_mask = '0;
  logic                  in_force_req = 1'b0;
  logic [ID_W-1:0]       in_pkt_id = '0;
  logic [VERD_W-1:0]     in_rule_verdict = '0;
  logic                  in_is_tcp = 1'b0;
  logic                  in_tcp_syn = 1'b0;
  logic                  in_tcp_psh = 1'b0;
  logic [NOW_W-1:0]      in_now_us = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_flush_chain;
  logic [ID_W-1:0]       out_flush_pkt_id;
  logic [VERD_W-1:0]     out_flush_verdict;
  logic [CNT_W-1:0]      out_flush_count;
  logic                  out_last_flag;

  // Shadow copy of the registers and per-chain batch state
  logic [CNT_W-1:0]     lim_reg;
  logic [TIMEOUT_W-1:0] tmo_reg;
  logic [VERD_W-1:0]    dflt_in_reg;
  logic [VERD_W-1:0]    dflt_out_reg;
  logic [CNT_W-1:0]     pend_cnt [2];
  logic [ID_W-1:0]      newest_id [2];
  logic [VERD_W-1:0]    batch_vd [2];
  logic [NOW_W-1:0]     first_us [2];

  flush_t            batch_releases_due[$];
  int                mismatches = 0;
  int                cycle_cnt = 0;
  int                out_hold = 0;
  bit                quiet = 1'b0;
  logic [NOW_W-1:0]  t_us = '0;
  logic [VERD_W-1:0] sticky_rv [2] = '{3'd0, 3'd0};

  verdict_batch_coalescer_top i_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Draw an idle count: often none, sometimes short, sometimes long
  function automatic int pick_wait();
    if (quiet) return 0;
    case ($urandom_range(0, 3))
      0, 1:    return 0;
      2:       return $urandom_range(1, 3);
      default: return $urandom_range(0, 16);
    endcase
  endfunction

  function automatic void reset_shadow();
    lim_reg      = LIMIT_RST;
    tmo_reg      = TIMEOUT_RST;
    dflt_in_reg  = DEF_VERD_RST;
    dflt_out_reg = DEF_VERD_RST;
    for (int c = 0; c < 2; c++) begin
      pend_cnt[c]  = '0;
      newest_id[c] = '0;
      batch_vd[c]  = NO_VERDICT_MARK;
      first_us[c]  = '0;
    end
  endfunction

  // Release a chain's batch if it is non-empty and a flush condition holds
  function automatic void release_batch(input logic c, input bit push_it,
                                        input logic [NOW_W-1:0] now,
                                        ref flush_t rel[$]);
    logic [NOW_W-1:0] age;
    flush_t f;
    if (pend_cnt[c] == '0) return;
    age = now - first_us[c];
    if (!(push_it || pend_cnt[c] >= lim_reg || age >= tmo_reg)) return;
    f.chain   = c;
    f.pkt_id  = newest_id[c];
    f.verdict = batch_vd[c];
    f.count   = pend_cnt[c];
    f.last    = 1'b0;
    rel.push_back(f);
    pend_cnt[c] = '0;
  endfunction

  // Advance the batch state by one accepted request and queue its releases
  function automatic void apply_request(input coal_req_t r);
    flush_t rel[$];
    logic [VERD_W-1:0] v;
    logic c;
    if (r.mode == MODE_PACKET) begin
      c = r.chain;
      v = r.rule_verdict;
      if (v >= NO_MATCH_CODE) v = (c == CHAIN_OUT) ? dflt_out_reg : dflt_in_reg;
      if (v != batch_vd[c] && pend_cnt[c] != '0) release_batch(c, 1'b1, r.now_us, rel);
      batch_vd[c]  = v;
      newest_id[c] = r.pkt_id;
      if (pend_cnt[c] == '0) first_us[c] = r.now_us;
      if (pend_cnt[c] != CNT_MAX) pend_cnt[c]++;
      release_batch(c, r.is_tcp && (r.tcp_syn || r.tcp_psh), r.now_us, rel);
    end else begin
      if (r.poll_mask[POLL_BIT_OUT]) release_batch(CHAIN_OUT, r.force_req, r.now_us, rel);
      if (r.poll_mask[POLL_BIT_IN])  release_batch(CHAIN_IN, r.force_req, r.now_us, rel);
    end
    if (rel.size() != 0) rel[rel.size()-1].last = 1'b1;
    foreach (rel[i]) batch_releases_due.push_back(rel[i]);
  endfunction

  // Check each accepted release and draw the next stall
  always @(posedge clk) begin
    flush_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (batch_releases_due.size() == 0) begin
        $error("unexpected flush: chain %0d id %0h verdict %0d count %0d",
               out_flush_chain, out_flush_pkt_id, out_flush_verdict, out_flush_count);
        mismatches++;
      end else begin
        want = batch_releases_due.pop_front();
        if (out_flush_chain !== want.chain) begin
          $error("flush_chain: expected %0d, got %0d", want.chain, out_flush_chain);
          mismatches++;
        end
        if (out_flush_pkt_id !== want.pkt_id) begin
          $error("flush_pkt_id: expected %0h, got %0h", want.pkt_id,
                 out_flush_pkt_id);
          mismatches++;
        end
        if (out_flush_verdict !== want.verdict) begin
          $error("flush_verdict: expected %0d, got %0d", want.verdict, out_flush_verdict);
          mismatches++;
        end
        if (out_flush_count !== want.count) begin
          $error("flush_count: expected %0d, got %0d", want.count, out_flush_count);
          mismatches++;
        end
        if (out_last_flag !== want.last) begin
          $error("last_flag: expected %0d, got %0d", want.last, out_last_flag);
          mismatches++;
        end
      end
      out_hold = pick_wait();
    end
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one request after a random gap and hold it until accepted
  task automatic send_req(input coal_req_t r);
    int gap;
    gap = pick_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= r.mode;
    in_chain        <= r.chain;
    in_poll_mask    <= r.poll_mask;
    in_force_req    <= r.force_req;
    in_pkt_id       <= r.pkt_id;
    in_rule_verdict <= r.rule_verdict;
    in_is_tcp       <= r.is_tcp;
    in_tcp_syn      <= r.tcp_syn;
    in_tcp_psh      <= r.tcp_psh;
    in_now_us       <= r.now_us;
    do @(posedge clk); while (in_stall);
    apply_request(r);
  endtask

  // Drop the request line and wait until every release is out
  task automatic settle();
    in_valid <= 1'b0;
    while (batch_releases_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BATCH_LIMIT:     lim_reg      = val[CNT_W-1:0];
      REG_BATCH_TIMEOUT:   tmo_reg      = val[TIMEOUT_W-1:0];
      REG_DEF_VERDICT_IN:  dflt_in_reg  = val[VERD_W-1:0];
      REG_DEF_VERDICT_OUT: dflt_out_reg = val[VERD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] lim, input logic [CFG_DATA_W-1:0] tmo,
                          input logic [CFG_DATA_W-1:0] din,
                          input logic [CFG_DATA_W-1:0] dout);
    settle();
    write_reg(REG_BATCH_LIMIT, lim);
    write_reg(REG_BATCH_TIMEOUT, tmo);
    write_reg(REG_DEF_VERDICT_IN, din);
    write_reg(REG_DEF_VERDICT_OUT, dout);
  endtask

  // Packet request; poll fields carry noise
  function automatic coal_req_t mk_packet(input logic c, input logic [ID_W-1:0] id,
                                          input logic [VERD_W-1:0] rv, input logic tcp,
                                          input logic syn, input logic psh,
                                          input logic [NOW_W-1:0] now);
    coal_req_t r;
    r.mode         = MODE_PACKET;
    r.chain        = c;
    r.poll_mask    = MASK_W'($urandom());
    r.force_req    = 1'($urandom());
    r.pkt_id       = id;
    r.rule_verdict = rv;
    r.is_tcp       = tcp;
    r.tcp_syn      = syn;
    r.tcp_psh      = psh;
    r.now_us       = now;
    return r;
  endfunction

  // Poll request; packet fields carry noise
  function automatic coal_req_t mk_poll(input logic [MASK_W-1:0] mask, input logic frc,
                                        input logic [NOW_W-1:0] now);
    coal_req_t r;
    r.mode         = MODE_POLL;
    r.chain        = 1'($urandom());
    r.poll_mask    = mask;
    r.force_req    = frc;
    r.pkt_id       = $urandom();
    r.rule_verdict = VERD_W'($urandom());
    r.is_tcp       = 1'($urandom());
    r.tcp_syn      = 1'($urandom());
    r.tcp_psh      = 1'($urandom());
    r.now_us       = now;
    return r;
  endfunction

  // Mostly runs of one verdict per chain, rare pushes, time mostly creeping
  function automatic coal_req_t rand_req();
    coal_req_t r;
    logic c;
    case ($urandom_range(0, 19))
      0:       t_us = NOW_W'({$urandom(), $urandom()});
      1:       t_us = NOW_MAX - NOW_W'($urandom_range(0, 30));
      default: t_us = t_us + NOW_W'($urandom_range(0, 15));
    endcase
    c = 1'($urandom());
    if ($urandom_range(0, 3) == 0) sticky_rv[c] = VERD_W'($urandom_range(0, 7));
    r = mk_packet(c, $urandom(), sticky_rv[c], 1'($urandom()),
                  $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0, t_us);
    if ($urandom_range(0, 3) == 0) r = mk_poll(MASK_W'($urandom()), $urandom_range(0, 2) == 0, t_us);
    return r;
  endfunction

  // Reset registers: limit one flushes every packet, unmatched takes verdict one
  task automatic test_reset_defaults();
    send_req(mk_packet(CHAIN_IN, 32'h0, NO_MATCH_CODE, 1'b0, 1'b0, 1'b0, '0));
    send_req(mk_packet(CHAIN_OUT, 32'hFFFF_FFFF, 3'd7, 1'b0, 1'b0, 1'b0, NOW_MAX));
    send_req(mk_packet(CHAIN_IN, 32'h1234_5678, 3'd0, 1'b1, 1'b0, 1'b0, 48'd10));
    send_req(mk_packet(CHAIN_OUT, 32'h8765_4321, NO_VERDICT_MARK, 1'b0, 1'b1, 1'b1, 48'd11));
    send_req(mk_poll(2'b00, 1'b1, 48'd12));
    send_req(mk_poll(2'b11, 1'b1, 48'd13));
  endtask

  // Verdict changes, TCP pushes and forced polls with a high limit
  task automatic test_verdict_change();
    set_regs(48'd100, TIMEOUT_RST, 48'd3, 48'd4);
    send_req(mk_packet(CHAIN_IN, 32'd1, 3'd2, 1'b0, 1'b0, 1'b0, 48'd100));
    send_req(mk_packet(CHAIN_IN, 32'd2, 3'd2, 1'b0, 1'b0, 1'b0, 48'd101));
    send_req(mk_packet(CHAIN_IN, 32'd3, NO_MATCH_CODE, 1'b0, 1'b0, 1'b0, 48'd102));
    send_req(mk_packet(CHAIN_OUT, 32'd4, 3'd7, 1'b0, 1'b0, 1'b0, 48'd103));
    send_req(mk_packet(CHAIN_OUT, 32'd5, 3'd4, 1'b0, 1'b0, 1'b0, 48'd104));
    send_req(mk_packet(CHAIN_OUT, 32'd6, 3'd0, 1'b0, 1'b0, 1'b0, 48'd105));
    send_req(mk_packet(CHAIN_IN, 32'd7, 3'd3, 1'b1, 1'b0, 1'b0, 48'd106));
    send_req(mk_packet(CHAIN_IN, 32'd8, 3'd3, 1'b0, 1'b1, 1'b1, 48'd107));
    send_req(mk_packet(CHAIN_IN, 32'd9, 3'd3, 1'b1, 1'b1, 1'b0, 48'd108));
    send_req(mk_packet(CHAIN_OUT, 32'd10, 3'd0, 1'b1, 1'b0, 1'b1, 48'd109));
    send_req(mk_packet(CHAIN_IN, 32'd11, 3'd1, 1'b0, 1'b0, 1'b0, 48'd110));
    send_req(mk_packet(CHAIN_OUT, 32'd12, 3'd1, 1'b0, 1'b0, 1'b0, 48'd111));
    send_req(mk_poll(2'b01, 1'b0, 48'd112));
    send_req(mk_poll(2'b10, 1'b1, 48'd113));
    send_req(mk_poll(2'b11, 1'b1, 48'd114));
    send_req(mk_packet(CHAIN_IN, 32'd13, 3'd2, 1'b0, 1'b0, 1'b0, 48'd115));
    send_req(mk_packet(CHAIN_OUT, 32'd14, 3'd2, 1'b0, 1'b0, 1'b0, 48'd116));
    send_req(mk_poll(2'b11, 1'b1, 48'd117));
  endtask

  // Age checks across the time wrap, reaching the timeout exactly
  task automatic test_timeout_wrap();
    set_regs(48'd100, 48'd10, 48'd1, 48'd1);
    send_req(mk_packet(CHAIN_OUT, 32'd20, 3'd2, 1'b0, 1'b0, 1'b0, NOW_MAX - 48'd3));
    send_req(mk_poll(2'b10, 1'b0, 48'd5));
    send_req(mk_poll(2'b10, 1'b0, 48'd6));
    send_req(mk_packet(CHAIN_IN, 32'd21, 3'd2, 1'b0, 1'b0, 1'b0, 48'd1000));
    send_req(mk_packet(CHAIN_IN, 32'd22, 3'd2, 1'b0, 1'b0, 1'b0, 48'd1010));
    send_req(mk_packet(CHAIN_IN, 32'd23, 3'd2, 1'b0, 1'b0, 1'b0, 48'd2000));
    send_req(mk_packet(CHAIN_IN, 32'd24, 3'd3, 1'b0, 1'b0, 1'b0, 48'd2020));
    send_req(mk_poll(2'b01, 1'b1, 48'd2021));
  endtask

  // Limit zero flushes at once; out-of-range defaults are used as written
  task automatic test_limit_zero();
    set_regs(48'd0, TIMEOUT_RST, 48'd6, 48'd7);
    send_req(mk_packet(CHAIN_IN, 32'd30, NO_MATCH_CODE, 1'b0, 1'b0, 1'b0, 48'd3000));
    send_req(mk_packet(CHAIN_OUT, 32'd31, 3'd7, 1'b0, 1'b0, 1'b0, 48'd3001));
    send_req(mk_poll(2'b11, 1'b0, 48'd3002));
  endtask

  // Fill one batch back to back until it reaches the limit
  task automatic test_full_batch();
    set_regs(CFG_DATA_W'(FULL_BATCH), TIMEOUT_RST, 48'd0, 48'd0);
    quiet = 1'b1;
    for (int i = 0; i < FULL_BATCH; i++) begin
      send_req(mk_packet(CHAIN_IN, ID_W'(i), 3'd2, 1'b0, 1'b0, 1'b0, NOW_W'(i)));
    end
    quiet = 1'b0;
  endtask

  // Random requests under several register settings
  task automatic test_random();
    logic [CFG_DATA_W-1:0] lim;
    logic [CFG_DATA_W-1:0] tmo;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      lim = {$urandom(), 16'($urandom_range(1, 8))};
      tmo = ($urandom_range(0, 1) == 0) ? 48'($urandom_range(0, 60))
                                        : 48'({$urandom(), $urandom()});
      case (ph)
        0: begin lim = '0;                      tmo = TIMEOUT_RST; end
        1: begin lim = CFG_DATA_W'(CNT_MAX);    tmo = '0;          end
        2: begin lim = CFG_DATA_W'(CNT_MAX);    tmo = TIMEOUT_RST; end
        3: lim = CFG_DATA_W'({$urandom(), $urandom()});
        default: ;
      endcase
      set_regs(lim, tmo, {$urandom(), 16'($urandom())}, {$urandom(), 16'($urandom())});
      quiet = (ph == 5);
      repeat (PHASE_REQS) send_req(rand_req());
      quiet = 1'b0;
    end
  endtask

  initial begin
    reset_shadow();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_verdict_change();
    test_timeout_wrap();
    test_limit_zero();
    test_full_batch();
    test_random();
    settle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: verdict_batch_coalescer_top.f
rtl/core/vbc_pkg.sv
rtl/core/verdict_batch_coalescer_top.sv
rtl/core/vbc_checker.sv
verif/verdict_batch_coalescer_top_test.sv
